// ===== rtl/core/trt_pkg.sv =====
// ----------------------------------------------------------------------------
// trt_pkg
// Shared types, register indexes, reset values and constants for the throw
// reaction timer.
// ----------------------------------------------------------------------------
`default_nettype none

package trt_pkg;

   // field widths
   localparam int unsigned MS_W      = 16;
   localparam int unsigned ELAPSED_W = 17;
   localparam int unsigned SENS_W    = 7;
   localparam int unsigned ACCEL_W   = 16;
   localparam int unsigned PHASE_W   = 3;
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned CSR_DATA_W = 16;

   // register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_COUNTDOWN   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_DELAY   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_DELAY   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SENSITIVITY = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_THROW_BEEP  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT     = 3'd5;

   // register reset values
   localparam logic [MS_W-1:0]   RST_COUNTDOWN   = 16'd3000;
   localparam logic [MS_W-1:0]   RST_MIN_DELAY   = 16'd1000;
   localparam logic [MS_W-1:0]   RST_MAX_DELAY   = 16'd4000;
   localparam logic [SENS_W-1:0] RST_SENSITIVITY = 7'd50;
   localparam logic [MS_W-1:0]   RST_THROW_BEEP  = 16'd300;
   localparam logic [MS_W-1:0]   RST_TIMEOUT     = 16'd30000;

   // phase codes
   localparam logic [PHASE_W-1:0] PH_IDLE   = 3'd0;
   localparam logic [PHASE_W-1:0] PH_COUNT  = 3'd1;
   localparam logic [PHASE_W-1:0] PH_ARMED  = 3'd2;
   localparam logic [PHASE_W-1:0] PH_MEAS   = 3'd3;
   localparam logic [PHASE_W-1:0] PH_REPORT = 3'd4;

   // detection: 10000*m >= (16384*(99 + 2*s))^2, and 16384^2 = 2^28
   localparam logic [13:0]       PCT_SCALE   = 14'd10000;
   localparam int unsigned       G_SQ_SHIFT  = 28;
   localparam logic [8:0]        PCT_BASE    = 9'd99;
   localparam logic [SENS_W-1:0] SENS_MAX    = 7'd100;
   localparam logic [SENS_W-1:0] SENS_ANY    = 7'd0;

   // elapsed counter saturation
   localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = 17'h1FFFF;
   localparam logic [MS_W-1:0]      MS_MAX      = 16'hFFFF;

   typedef struct packed {
      logic                       start_request;
      logic signed [ACCEL_W-1:0]  accel_x;
      logic signed [ACCEL_W-1:0]  accel_y;
      logic signed [ACCEL_W-1:0]  accel_z;
      logic                       accel_valid;
      logic [MS_W-1:0]            random_word;
   } req_word_type;

   typedef struct packed {
      logic [PHASE_W-1:0] phase;
      logic               buzzer_on;
      logic               ready_cue;
      logic               confirm_cue;
      logic               result_valid;
      logic [MS_W-1:0]    result_ms;
      logic               timed_out;
   } rsp_word_type;

   typedef struct packed {
      logic [MS_W-1:0]   countdown_ms;
      logic [MS_W-1:0]   min_delay_ms;
      logic [MS_W-1:0]   max_delay_ms;
      logic [SENS_W-1:0] sensitivity_pct;
      logic [MS_W-1:0]   throw_beep_ms;
      logic [MS_W-1:0]   timeout_ms;
   } cfg_type;

   // a tick after classification
   typedef struct packed {
      logic            start_request;
      logic            throw_seen;
      logic [MS_W-1:0] armed_draw;
   } cls_word_type;

endpackage

`default_nettype wire

// ===== rtl/core/trt_front.sv =====
// ----------------------------------------------------------------------------
// trt_front
// Takes one tick word, computes the throw detection flag from the squared
// acceleration magnitude and draws the armed wait with a bit-serial modulo.
// ----------------------------------------------------------------------------
`default_nettype none

module trt_front (
   input  wire                   clock,
   input  wire                   reset,
   input  trt_pkg::cfg_type      cfg,
   input  wire                   push,
   output logic                  full,
   input  trt_pkg::req_word_type req_word,
   output logic                  cls_valid,
   output trt_pkg::cls_word_type cls_word,
   input  wire                   cls_full
);

   localparam logic [1:0] F_IDLE = 2'd0;
   localparam logic [1:0] F_BUSY = 2'd1;
   localparam logic [1:0] F_DONE = 2'd2;

   localparam logic [4:0] STEP_LAST = 5'd16;

   logic [1:0]  state_ff, state_in;
   logic [4:0]  step_ff, step_in;

   logic                  start_ff, start_in;
   logic                  valid_ff, valid_in;
   logic signed [15:0]    ax_ff, ax_in;
   logic signed [15:0]    ay_ff, ay_in;
   logic signed [15:0]    az_ff, az_in;
   logic [15:0]           rw_ff, rw_in;
   logic [16:0]           span_ff, span_in;
   logic [16:0]           rem_ff, rem_in;
   logic [30:0]           sq_ff, sq_in;
   logic [31:0]           acc_ff, acc_in;
   logic [45:0]           prod_ff, prod_in;
   logic [17:0]           q2_ff, q2_in;
   logic                  hit_ff, hit_in;

   logic signed [15:0] axis_sel;
   logic signed [31:0] sq_full;
   logic [15:0]        hi_bound;
   logic [8:0]         pct_q;
   logic [16:0]        rem_shift;
   logic               accept;
   logic               sens_ok;

   assign accept = push && !full;
   assign full   = (state_ff != F_IDLE);

   // span of the draw, max raised to min
   assign hi_bound = (cfg.max_delay_ms < cfg.min_delay_ms) ? cfg.min_delay_ms
                                                          : cfg.max_delay_ms;

   // one shared squaring multiplier, axis picked by step
   always_comb begin
      unique case (step_ff[1:0])
         2'd0:    axis_sel = ax_ff;
         2'd1:    axis_sel = ay_ff;
         default: axis_sel = az_ff;
      endcase
   end
   assign sq_full = axis_sel * axis_sel;

   assign pct_q     = trt_pkg::PCT_BASE + {1'b0, cfg.sensitivity_pct, 1'b0};
   assign rem_shift = {rem_ff[15:0], rw_ff[15]};

   // step sequencer
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      start_in = start_ff;
      valid_in = valid_ff;
      ax_in    = ax_ff;
      ay_in    = ay_ff;
      az_in    = az_ff;
      rw_in    = rw_ff;
      span_in  = span_ff;
      rem_in   = rem_ff;
      sq_in    = sq_ff;
      acc_in   = acc_ff;
      prod_in  = prod_ff;
      q2_in    = q2_ff;
      hit_in   = hit_ff;
      unique case (state_ff)
         F_IDLE: begin
            if (accept) begin
               state_in = F_BUSY;
               step_in  = '0;
               start_in = req_word.start_request;
               valid_in = req_word.accel_valid;
               ax_in    = req_word.accel_x;
               ay_in    = req_word.accel_y;
               az_in    = req_word.accel_z;
               rw_in    = req_word.random_word;
               span_in  = {1'b0, hi_bound} - {1'b0, cfg.min_delay_ms} + 17'd1;
               rem_in   = '0;
               acc_in   = '0;
            end
         end
         F_BUSY: begin
            // squares of x, y, z on steps 0..2, summed on steps 1..3
            sq_in = sq_full[30:0];
            if (step_ff >= 5'd1 && step_ff <= 5'd3) begin
               acc_in = acc_ff + {1'b0, sq_ff};
            end
            if (step_ff == 5'd4) begin
               prod_in = 46'(acc_ff) * 46'(trt_pkg::PCT_SCALE);
               q2_in   = 18'(pct_q * pct_q);
            end
            if (step_ff == 5'd5) begin
               hit_in = (prod_ff[45:trt_pkg::G_SQ_SHIFT] >= q2_ff);
            end
            // restoring modulo, one bit of the random word per step
            if (step_ff < STEP_LAST) begin
               rw_in  = {rw_ff[14:0], 1'b0};
               rem_in = (rem_shift >= span_ff) ? rem_shift - span_ff : rem_shift;
               step_in = step_ff + 5'd1;
            end else begin
               state_in = F_DONE;
            end
         end
         F_DONE: begin
            if (!cls_full) begin
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   // classified word
   assign sens_ok = (cfg.sensitivity_pct == trt_pkg::SENS_ANY) ||
                    ((cfg.sensitivity_pct <= trt_pkg::SENS_MAX) && hit_ff);
   assign cls_valid              = (state_ff == F_DONE);
   assign cls_word.start_request = start_ff;
   assign cls_word.throw_seen    = valid_ff && sens_ok;
   assign cls_word.armed_draw    = cfg.min_delay_ms + rem_ff[15:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      start_ff <= start_in;
      valid_ff <= valid_in;
      ax_ff    <= ax_in;
      ay_ff    <= ay_in;
      az_ff    <= az_in;
      rw_ff    <= rw_in;
      span_ff  <= span_in;
      rem_ff   <= rem_in;
      sq_ff    <= sq_in;
      acc_ff   <= acc_in;
      prod_ff  <= prod_in;
      q2_ff    <= q2_in;
      hit_ff   <= hit_in;
   end

endmodule

`default_nettype wire

// ===== rtl/core/trt_fifo.sv =====
// ----------------------------------------------------------------------------
// trt_fifo
// Two-entry queue of classified words between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module trt_fifo (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   wr_en,
   input  trt_pkg::cls_word_type wr_word,
   output logic                  full,
   input  wire                   rd_en,
   output trt_pkg::cls_word_type rd_word,
   output logic                  empty
);

   trt_pkg::cls_word_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_wr, do_rd;

   assign full    = (count_ff == 2'd2);
   assign empty   = (count_ff == 2'd0);
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;
   assign rd_word = entry_ff[rd_ptr_ff];

   // pointer and fill count
   always_comb begin
      wr_ptr_in = do_wr ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_rd ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, do_wr} - {1'b0, do_rd};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         entry_ff[wr_ptr_ff] <= wr_word;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/trt_back.sv =====
// ----------------------------------------------------------------------------
// trt_back
// Phase sequencer: steps the timer one tick per classified word and holds
// the result word in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module trt_back (
   input  wire                   clock,
   input  wire                   reset,
   input  trt_pkg::cfg_type      cfg,
   input  wire                   cls_empty,
   input  trt_pkg::cls_word_type cls_word,
   output logic                  cls_pop,
   output logic                  empty,
   input  wire                   pop,
   output trt_pkg::rsp_word_type rsp_word
);

   logic [2:0]  phase_ff, phase_in;
   logic [16:0] elapsed_ff, elapsed_in;
   logic [15:0] armed_ff, armed_in;
   logic        beep_ff, beep_in;
   logic [15:0] last_ms_ff, last_ms_in;
   logic        last_to_ff, last_to_in;
   logic        out_valid_ff, out_valid_in;
   trt_pkg::rsp_word_type out_word_ff, out_word_in;

   logic [16:0] elapsed_inc;
   logic        ready_cue;
   logic        confirm_cue;
   logic        rvalid;
   logic [15:0] rms;
   logic        rto;

   assign cls_pop = !cls_empty && (!out_valid_ff || pop);
   assign empty   = !out_valid_ff;
   assign rsp_word = out_word_ff;

   assign elapsed_inc = (elapsed_ff < trt_pkg::ELAPSED_MAX) ? elapsed_ff + 17'd1
                                                            : elapsed_ff;

   // one tick of the phase machine
   always_comb begin
      phase_in    = phase_ff;
      elapsed_in  = elapsed_ff;
      armed_in    = armed_ff;
      beep_in     = beep_ff;
      last_ms_in  = last_ms_ff;
      last_to_in  = last_to_ff;
      ready_cue   = 1'b0;
      confirm_cue = 1'b0;
      rvalid      = 1'b0;
      rms         = '0;
      rto         = 1'b0;
      unique case (phase_ff)
         trt_pkg::PH_IDLE: begin
            if (cls_word.start_request) begin
               beep_in    = 1'b0;
               elapsed_in = '0;
               phase_in   = trt_pkg::PH_COUNT;
            end
         end
         trt_pkg::PH_COUNT: begin
            elapsed_in = elapsed_inc;
            if (elapsed_inc >= {1'b0, cfg.countdown_ms}) begin
               armed_in   = cls_word.armed_draw;
               ready_cue  = 1'b1;
               elapsed_in = '0;
               phase_in   = trt_pkg::PH_ARMED;
            end
         end
         trt_pkg::PH_ARMED: begin
            elapsed_in = elapsed_inc;
            if (elapsed_inc >= {1'b0, armed_ff}) begin
               beep_in    = 1'b1;
               elapsed_in = '0;
               phase_in   = trt_pkg::PH_MEAS;
            end
         end
         trt_pkg::PH_MEAS: begin
            elapsed_in = elapsed_inc;
            if (beep_ff && elapsed_inc >= {1'b0, cfg.throw_beep_ms}) begin
               beep_in = 1'b0;
            end
            if (cls_word.throw_seen) begin
               last_ms_in  = elapsed_inc[16] ? trt_pkg::MS_MAX : elapsed_inc[15:0];
               last_to_in  = 1'b0;
               beep_in     = 1'b0;
               confirm_cue = 1'b1;
               elapsed_in  = '0;
               phase_in    = trt_pkg::PH_REPORT;
            end else if (elapsed_inc >= {1'b0, cfg.timeout_ms}) begin
               last_ms_in = '0;
               last_to_in = 1'b1;
               beep_in    = 1'b0;
               elapsed_in = '0;
               phase_in   = trt_pkg::PH_REPORT;
            end
         end
         trt_pkg::PH_REPORT: begin
            rvalid     = 1'b1;
            rms        = last_ms_ff;
            rto        = last_to_ff;
            elapsed_in = '0;
            phase_in   = trt_pkg::PH_IDLE;
         end
         default: begin
            elapsed_in = '0;
            beep_in    = 1'b0;
            phase_in   = trt_pkg::PH_IDLE;
         end
      endcase
   end

   // output register
   always_comb begin
      out_word_in              = out_word_ff;
      out_word_in.phase        = phase_in;
      out_word_in.buzzer_on    = beep_in;
      out_word_in.ready_cue    = ready_cue;
      out_word_in.confirm_cue  = confirm_cue;
      out_word_in.result_valid = rvalid;
      out_word_in.result_ms    = rms;
      out_word_in.timed_out    = rto;
      if (cls_pop) begin
         out_valid_in = 1'b1;
      end else if (pop) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= trt_pkg::PH_IDLE;
         elapsed_ff   <= '0;
         armed_ff     <= '0;
         beep_ff      <= 1'b0;
         last_ms_ff   <= '0;
         last_to_ff   <= 1'b1;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (cls_pop) begin
            phase_ff   <= phase_in;
            elapsed_ff <= elapsed_in;
            armed_ff   <= armed_in;
            beep_ff    <= beep_in;
            last_ms_ff <= last_ms_in;
            last_to_ff <= last_to_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cls_pop) begin
         out_word_ff <= out_word_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/throw_reaction_timer.sv =====
// ----------------------------------------------------------------------------
// throw_reaction_timer
// Millisecond-tick throw reaction timer: countdown, random armed wait,
// throw buzzer and accelerometer throw detection with a timed result.
// ----------------------------------------------------------------------------
// Each word pushed is one millisecond tick and yields exactly one result word.
// In the front the three axis squares share one multiplier and the armed-wait
// draw is a restoring modulo retiring one bit of the random word per cycle;
// the front takes no new word until it has handed the last one on. A two-word
// queue parts the front from the phase sequencer, which steps one tick per
// cycle into an output register while it is free or popped, so results may
// wait on pop while the next tick is already being classified. Register writes
// take effect at the next clock edge and are meant for idle periods.
`default_nettype none

module throw_reaction_timer (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   push,
   output logic                                  full,
   input  trt_pkg::req_word_type                 req_word,
   output logic                                  empty,
   input  wire                                   pop,
   output trt_pkg::rsp_word_type                 rsp_word,
   input  wire                                   csr_wr_en,
   input  wire [trt_pkg::CSR_IDX_W-1:0]          csr_index,
   input  wire [trt_pkg::CSR_DATA_W-1:0]         csr_wdata
);

   trt_pkg::cfg_type      cfg_ff, cfg_in;
   trt_pkg::cls_word_type front_word;
   trt_pkg::cls_word_type queue_word;
   logic                  front_valid;
   logic                  queue_full;
   logic                  queue_empty;
   logic                  queue_pop;

   // control register file
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            trt_pkg::CSR_COUNTDOWN:   cfg_in.countdown_ms    = csr_wdata;
            trt_pkg::CSR_MIN_DELAY:   cfg_in.min_delay_ms    = csr_wdata;
            trt_pkg::CSR_MAX_DELAY:   cfg_in.max_delay_ms    = csr_wdata;
            trt_pkg::CSR_SENSITIVITY: cfg_in.sensitivity_pct = csr_wdata[6:0];
            trt_pkg::CSR_THROW_BEEP:  cfg_in.throw_beep_ms   = csr_wdata;
            trt_pkg::CSR_TIMEOUT:     cfg_in.timeout_ms      = csr_wdata;
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.countdown_ms    <= trt_pkg::RST_COUNTDOWN;
         cfg_ff.min_delay_ms    <= trt_pkg::RST_MIN_DELAY;
         cfg_ff.max_delay_ms    <= trt_pkg::RST_MAX_DELAY;
         cfg_ff.sensitivity_pct <= trt_pkg::RST_SENSITIVITY;
         cfg_ff.throw_beep_ms   <= trt_pkg::RST_THROW_BEEP;
         cfg_ff.timeout_ms      <= trt_pkg::RST_TIMEOUT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // tick classification
   trt_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .push      (push),
      .full      (full),
      .req_word  (req_word),
      .cls_valid (front_valid),
      .cls_word  (front_word),
      .cls_full  (queue_full)
   );

   // queue between front and back
   trt_fifo u_fifo (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (front_valid),
      .wr_word (front_word),
      .full    (queue_full),
      .rd_en   (queue_pop),
      .rd_word (queue_word),
      .empty   (queue_empty)
   );

   // phase sequencer and result register
   trt_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cls_empty (queue_empty),
      .cls_word  (queue_word),
      .cls_pop   (queue_pop),
      .empty     (empty),
      .pop       (pop),
      .rsp_word  (rsp_word)
   );

endmodule

`default_nettype wire

// ===== tb/throw_reaction_timer_test.sv =====
// ----------------------------------------------------------------------------
// throw_reaction_timer_test
// Self-checking bench for the throw reaction timer. A short directed table
// walks each phase and the corner settings, then random ticks run under
// several timer settings and idle patterns. Every result word is checked
// field by field against a typed row or a cycle-free phase sequencer model.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module throw_reaction_timer_test;
   import trt_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int HOLD_CYCLES = 400;
   localparam int MAX_PRINTS  = 50;

   typedef enum logic {ROW_TICK, ROW_CFG} row_kind_e;

   typedef struct {
      row_kind_e    kind;
      req_word_type req;
      logic         known;
      rsp_word_type rsp;
      cfg_type      cfg;
   } stim_row_t;

   // ports
   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  push = 1'b0;
   logic                  full;
   req_word_type          req_word = '0;
   logic                  empty;
   logic                  pop = 1'b0;
   rsp_word_type          rsp_word;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // model state and settings
   cfg_type                tmr_cfg;
   logic [PHASE_W-1:0]     tmr_phase;
   logic [ELAPSED_W-1:0]   tmr_elapsed;
   logic [MS_W-1:0]        tmr_wait;
   logic                   tmr_buzz;
   logic [MS_W-1:0]        tmr_last_ms;
   logic                   tmr_last_to;

   rsp_word_type tick_outcomes[$];
   stim_row_t    stim_table[$];
   int           mismatch_count = 0;
   int           cycle_count = 0;
   int           tx_idle_pct = 0;
   int           rx_stall_pct = 0;
   int           hold_asks = 0;
   int           hold_seen = 0;
   int           hold_left = 0;

   throw_reaction_timer u_top (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_word  (req_word),
      .empty     (empty),
      .pop       (pop),
      .rsp_word  (rsp_word),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #6 clock = ~clock;

   task automatic note_mismatch(input string msg);
      if (mismatch_count < MAX_PRINTS)
         $display("mismatch at cycle %0d: %s", cycle_count, msg);
      mismatch_count++;
   endtask

   function automatic void count_ms();
      if (tmr_elapsed != ELAPSED_MAX)
         tmr_elapsed++;
   endfunction

   // squared magnitude against the squared threshold, all in integers
   function automatic logic throw_detected(input req_word_type w);
      longint x, y, z;
      longint unsigned m, t;
      if (!w.accel_valid)
         return 1'b0;
      if (tmr_cfg.sensitivity_pct == SENS_ANY)
         return 1'b1;
      if (tmr_cfg.sensitivity_pct > SENS_MAX)
         return 1'b0;
      x = longint'($signed(w.accel_x));
      y = longint'($signed(w.accel_y));
      z = longint'($signed(w.accel_z));
      m = longint'(x * x + y * y + z * z);
      t = 64'd16384 * (64'd99 + 64'd2 * tmr_cfg.sensitivity_pct);
      return (64'd10000 * m) >= (t * t);
   endfunction

   // one millisecond tick through the phase sequencer
   function automatic rsp_word_type next_tick_outcome(input req_word_type w);
      rsp_word_type r;
      int unsigned lo, hi, span;
      r = '0;
      case (tmr_phase)
         PH_IDLE: begin
            if (w.start_request) begin
               tmr_buzz = 1'b0;
               tmr_elapsed = '0;
               tmr_phase = PH_COUNT;
            end
         end
         PH_COUNT: begin
            count_ms();
            if (tmr_elapsed >= tmr_cfg.countdown_ms) begin
               lo = tmr_cfg.min_delay_ms;
               hi = tmr_cfg.max_delay_ms;
               if (hi < lo)
                  hi = lo;
               span = hi - lo + 1;
               tmr_wait = MS_W'(lo + (int'(w.random_word) % span));
               r.ready_cue = 1'b1;
               tmr_elapsed = '0;
               tmr_phase = PH_ARMED;
            end
         end
         PH_ARMED: begin
            count_ms();
            if (tmr_elapsed >= tmr_wait) begin
               tmr_buzz = 1'b1;
               tmr_elapsed = '0;
               tmr_phase = PH_MEAS;
            end
         end
         PH_MEAS: begin
            count_ms();
            if (tmr_buzz && tmr_elapsed >= tmr_cfg.throw_beep_ms)
               tmr_buzz = 1'b0;
            if (throw_detected(w)) begin
               tmr_last_ms = (tmr_elapsed > MS_MAX) ? MS_MAX : tmr_elapsed[MS_W-1:0];
               tmr_last_to = 1'b0;
               tmr_buzz = 1'b0;
               r.confirm_cue = 1'b1;
               tmr_elapsed = '0;
               tmr_phase = PH_REPORT;
            end else if (tmr_elapsed >= tmr_cfg.timeout_ms) begin
               tmr_last_ms = '0;
               tmr_last_to = 1'b1;
               tmr_buzz = 1'b0;
               tmr_elapsed = '0;
               tmr_phase = PH_REPORT;
            end
         end
         PH_REPORT: begin
            r.result_valid = 1'b1;
            r.result_ms = tmr_last_ms;
            r.timed_out = tmr_last_to;
            tmr_elapsed = '0;
            tmr_phase = PH_IDLE;
         end
         default: begin
            tmr_elapsed = '0;
            tmr_buzz = 1'b0;
            tmr_phase = PH_IDLE;
         end
      endcase
      r.phase = tmr_phase;
      r.buzzer_on = tmr_buzz;
      return r;
   endfunction

   function automatic req_word_type mk_req(input logic start, input int x, input int y,
                                           input int z, input logic valid, input int rnd);
      req_word_type w;
      w.start_request = start;
      w.accel_x = ACCEL_W'(x);
      w.accel_y = ACCEL_W'(y);
      w.accel_z = ACCEL_W'(z);
      w.accel_valid = valid;
      w.random_word = MS_W'(rnd);
      return w;
   endfunction

   function automatic rsp_word_type mk_rsp(input logic [PHASE_W-1:0] ph, input logic buzz,
                                           input logic rdy, input logic conf, input logic rv,
                                           input int ms, input logic to);
      rsp_word_type r;
      r.phase = ph;
      r.buzzer_on = buzz;
      r.ready_cue = rdy;
      r.confirm_cue = conf;
      r.result_valid = rv;
      r.result_ms = MS_W'(ms);
      r.timed_out = to;
      return r;
   endfunction

   function automatic cfg_type mk_cfg(input int cd, input int mn, input int mx, input int sens,
                                      input int beep, input int tmo);
      cfg_type c;
      c.countdown_ms = MS_W'(cd);
      c.min_delay_ms = MS_W'(mn);
      c.max_delay_ms = MS_W'(mx);
      c.sensitivity_pct = SENS_W'(sens);
      c.throw_beep_ms = MS_W'(beep);
      c.timeout_ms = MS_W'(tmo);
      return c;
   endfunction

   function automatic void add_tick(input req_word_type w, input logic known,
                                    input rsp_word_type r);
      stim_row_t row;
      row.kind = ROW_TICK;
      row.req = w;
      row.known = known;
      row.rsp = r;
      row.cfg = '0;
      stim_table.push_back(row);
   endfunction

   function automatic void add_cfg(input cfg_type c);
      stim_row_t row;
      row.kind = ROW_CFG;
      row.req = '0;
      row.known = 1'b0;
      row.rsp = '0;
      row.cfg = c;
      stim_table.push_back(row);
   endfunction

   // random tick: rest, throw-like, corner or fully random acceleration
   function automatic req_word_type draw_tick(input bit narrow_draw);
      req_word_type w;
      int unsigned pick, axis, mag;
      w.start_request = ($urandom_range(99) < 45);
      w.accel_valid = ($urandom_range(99) < 85);
      w.random_word = narrow_draw ? MS_W'($urandom_range(15)) : MS_W'($urandom);
      pick = $urandom_range(99);
      if (pick < 35) begin
         w.accel_x = ACCEL_W'($urandom_range(600) - 300);
         w.accel_y = ACCEL_W'($urandom_range(600) - 300);
         w.accel_z = ACCEL_W'(16384 + $urandom_range(600) - 300);
      end else if (pick < 70) begin
         axis = $urandom_range(2);
         mag = $urandom_range(32767, 16384);
         if ($urandom_range(1))
            mag = -mag;
         w.accel_x = (axis == 0) ? ACCEL_W'(mag) : ACCEL_W'($urandom_range(8000) - 4000);
         w.accel_y = (axis == 1) ? ACCEL_W'(mag) : ACCEL_W'($urandom_range(8000) - 4000);
         w.accel_z = (axis == 2) ? ACCEL_W'(mag) : ACCEL_W'($urandom_range(8000) - 4000);
      end else if (pick < 78) begin
         w.accel_x = ($urandom_range(1)) ? 16'sh8000 : 16'sh7FFF;
         w.accel_y = ($urandom_range(1)) ? 16'sh8000 : 16'sh0000;
         w.accel_z = ($urandom_range(1)) ? 16'sh7FFF : 16'sh0000;
      end else begin
         w.accel_x = ACCEL_W'($urandom);
         w.accel_y = ACCEL_W'($urandom);
         w.accel_z = ACCEL_W'($urandom);
      end
      return w;
   endfunction

   // offer one word at the falling edge, hold it until accepted
   task automatic send_tick(input req_word_type w, input logic known,
                            input rsp_word_type typed_rsp);
      rsp_word_type predicted;
      while ($urandom_range(99) < tx_idle_pct) begin
         push <= 1'b0;
         @(negedge clock);
      end
      push <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (full);
      predicted = next_tick_outcome(w);
      tick_outcomes.push_back(known ? typed_rsp : predicted);
      @(negedge clock);
   endtask

   // stop offering and wait for every result word
   task automatic settle();
      push <= 1'b0;
      while (tick_outcomes.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_W'(data);
      @(negedge clock);
   endtask

   task automatic program_timer(input cfg_type c);
      write_reg(CSR_COUNTDOWN, c.countdown_ms);
      write_reg(CSR_MIN_DELAY, c.min_delay_ms);
      write_reg(CSR_MAX_DELAY, c.max_delay_ms);
      write_reg(CSR_SENSITIVITY, c.sensitivity_pct);
      write_reg(CSR_THROW_BEEP, c.throw_beep_ms);
      write_reg(CSR_TIMEOUT, c.timeout_ms);
      csr_wr_en <= 1'b0;
      tmr_cfg = c;
   endtask

   // result side: random stalls plus an occasional long hold-off
   always @(negedge clock) begin
      if (hold_seen != hold_asks) begin
         hold_seen = hold_asks;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         pop <= 1'b0;
      end else begin
         pop <= ($urandom_range(99) >= rx_stall_pct);
      end
   end

   // compare each accepted result word with the oldest expectation
   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset && pop && !empty) begin
         if (tick_outcomes.size() == 0) begin
            note_mismatch("result word with nothing expected");
         end else begin
            want = tick_outcomes.pop_front();
            if (rsp_word.phase !== want.phase)
               note_mismatch($sformatf("phase %0d want %0d", rsp_word.phase, want.phase));
            if (rsp_word.buzzer_on !== want.buzzer_on)
               note_mismatch($sformatf("buzzer_on %b want %b", rsp_word.buzzer_on,
                                       want.buzzer_on));
            if (rsp_word.ready_cue !== want.ready_cue)
               note_mismatch($sformatf("ready_cue %b want %b", rsp_word.ready_cue,
                                       want.ready_cue));
            if (rsp_word.confirm_cue !== want.confirm_cue)
               note_mismatch($sformatf("confirm_cue %b want %b", rsp_word.confirm_cue,
                                       want.confirm_cue));
            if (rsp_word.result_valid !== want.result_valid)
               note_mismatch($sformatf("result_valid %b want %b", rsp_word.result_valid,
                                       want.result_valid));
            if (rsp_word.result_ms !== want.result_ms)
               note_mismatch($sformatf("result_ms %0d want %0d", rsp_word.result_ms,
                                       want.result_ms));
            if (rsp_word.timed_out !== want.timed_out)
               note_mismatch($sformatf("timed_out %b want %b", rsp_word.timed_out,
                                       want.timed_out));
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[throw_reaction_timer] ERROR");
         $finish;
      end
   end

   initial begin
      cfg_type c;
      int      n_ticks;
      bit      narrow_draw;

      // model after reset
      tmr_cfg = mk_cfg(RST_COUNTDOWN, RST_MIN_DELAY, RST_MAX_DELAY, RST_SENSITIVITY,
                       RST_THROW_BEEP, RST_TIMEOUT);
      tmr_phase = PH_IDLE;
      tmr_elapsed = '0;
      tmr_wait = '0;
      tmr_buzz = 1'b0;
      tmr_last_ms = '0;
      tmr_last_to = 1'b1;

      // short timings: a throw at 2 g, then a timeout
      add_cfg(mk_cfg(2, 1, 3, 50, 1, 3));
      add_tick(mk_req(0, 0, 0, 0, 0, 0), 1, mk_rsp(PH_IDLE, 0, 0, 0, 0, 0, 0));
      add_tick(mk_req(1, 0, 0, 16384, 1, 0), 1, mk_rsp(PH_COUNT, 0, 0, 0, 0, 0, 0));
      add_tick(mk_req(1, 0, 0, 16384, 1, 0), 0, '0);
      add_tick(mk_req(0, 0, 0, 16384, 1, 'hFFFF), 0, '0);
      add_tick(mk_req(0, 0, 0, 16384, 1, 0), 0, '0);
      add_tick(mk_req(0, -32768, -32768, -32768, 0, 0), 0, '0);
      add_tick(mk_req(0, -32768, 0, 0, 1, 0), 0, '0);
      add_tick(mk_req(0, 0, 0, 0, 1, 0), 0, '0);
      add_tick(mk_req(1, 32767, 32767, 32767, 1, 0), 0, '0);
      add_tick(mk_req(0, 0, 0, 16384, 1, 0), 0, '0);
      add_tick(mk_req(0, 0, 0, 16384, 1, 0), 0, '0);
      add_tick(mk_req(0, 0, 0, 16384, 1, 0), 0, '0);
      add_tick(mk_req(0, 0, 0, 16384, 1, 0), 0, '0);
      add_tick(mk_req(0, 0, 0, 16384, 1, 0), 0, '0);
      add_tick(mk_req(0, 0, 0, 16384, 1, 0), 0, '0);
      add_tick(mk_req(0, 0, 0, 0, 0, 0), 1, mk_rsp(PH_IDLE, 0, 0, 0, 1, 0, 1));
      // zero countdown, max below min, sensitivity zero detects anything valid
      add_cfg(mk_cfg(0, 2, 1, 0, 0, 0));
      add_tick(mk_req(1, 0, 0, 0, 0, 0), 0, '0);
      add_tick(mk_req(0, 0, 0, 0, 0, 'hAAAA), 0, '0);
      add_tick(mk_req(0, 0, 0, 0, 1, 'h5555), 0, '0);
      add_tick(mk_req(0, 0, 0, 0, 1, 0), 0, '0);
      add_tick(mk_req(0, 0, 0, 0, 1, 0), 0, '0);
      add_tick(mk_req(0, 0, 0, 0, 1, 0), 0, '0);
      // sensitivity above range never detects, zero timeout ends at once
      add_cfg(mk_cfg(0, 0, 0, 127, 'hFFFF, 0));
      add_tick(mk_req(1, 0, 0, 0, 1, 0), 0, '0);
      add_tick(mk_req(0, 0, 0, 0, 1, 'hFFFF), 0, '0);
      add_tick(mk_req(0, 0, 0, 0, 1, 0), 0, '0);
      add_tick(mk_req(0, -32768, 0, 0, 1, 0), 0, '0);
      add_tick(mk_req(0, 0, 0, 0, 1, 0), 1, mk_rsp(PH_IDLE, 0, 0, 0, 1, 0, 1));

      // reset, then the directed table
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      foreach (stim_table[i]) begin
         if (stim_table[i].kind == ROW_CFG) begin
            settle();
            program_timer(stim_table[i].cfg);
         end else begin
            send_tick(stim_table[i].req, stim_table[i].known, stim_table[i].rsp);
         end
      end

      // random phases over settings and idle patterns
      for (int p = 0; p < 12; p++) begin
         settle();
         case (p % 4)
            0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
            1: begin tx_idle_pct = 83; rx_stall_pct = 0;  end
            2: begin tx_idle_pct = 0;  rx_stall_pct = 83; end
            default: begin tx_idle_pct = 34; rx_stall_pct = 34; end
         endcase
         n_ticks = 85;
         narrow_draw = 0;
         c = mk_cfg($urandom_range(6), $urandom_range(6), $urandom_range(8),
                    ($urandom_range(99) < 25) ? $urandom_range(127) : $urandom_range(100, 40),
                    $urandom_range(8), $urandom_range(15));
         // all at top, sensitivity at SENS_MAX; short so no wait is ever drawn
         if (p == 3) begin
            c = mk_cfg('hFFFF, 'hFFFF, 'hFFFF, SENS_MAX, 'hFFFF, 'hFFFF);
            n_ticks = 30;
         end
         // full-width draw span, kept short through small random words
         if (p == 7) begin
            c.min_delay_ms = '0;
            c.max_delay_ms = MS_MAX;
            narrow_draw = 1;
         end
         if (p == 9)
            c.max_delay_ms = '0;
         program_timer(c);
         // long hold-off on the result side so the input stalls
         if (p == 4)
            hold_asks++;
         repeat (n_ticks) send_tick(draw_tick(narrow_draw), 1'b0, '0);
      end

      settle();
      repeat (40) @(negedge clock);
      if (mismatch_count == 0)
         $display("[throw_reaction_timer] OK");
      else
         $display("[throw_reaction_timer] ERROR");
      $finish;
   end

endmodule
